// File: hdl/dplm_pkg.sv
// shared types and constants of the dual prefix list matcher
`default_nettype none
package dplm_pkg;

  localparam int LIST_ENTRIES = 1024;
  localparam int IDX_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam int CNT_W = $clog2(LIST_ENTRIES + 1);
  localparam int ADDR_W = 128;
  localparam int PLEN_W = 8;
  localparam logic [PLEN_W-1:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [PLEN_W-1:0] V6_MAX_PREFIX = 8'd128;
  localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(LIST_ENTRIES);

  typedef enum logic [0:0] {
    OP_APPEND   = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              fam;
    logic [PLEN_W-1:0] prefix;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic do_append;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_empty;
    logic scan_last;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/dplm_ctrl.sv
// controller state machine of the dual prefix list matcher
`default_nettype none
module dplm_ctrl
  import dplm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire logic  in_op,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (op_t'(in_op) == OP_APPEND) begin
            state_nxt = ST_APPEND;
          end else if (stat.scan_empty) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_APPEND: begin
        cmd.do_append = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// File: hdl/dplm_datapath.sv
// entry stores, list counts, scan compare and result register
`default_nettype none
module dplm_datapath
  import dplm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic              in_sel,
  input  wire logic              in_first,
  input  wire logic              in_v6,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [PLEN_W-1:0] in_plen,
  output logic                   res_first,
  output logic                   res_second,
  output logic                   res_status
);

  entry_t mem0 [LIST_ENTRIES];
  entry_t mem1 [LIST_ENTRIES];
  entry_t rd0_r, rd1_r;

  logic [CNT_W-1:0] cnt0_r, cnt1_r;
  logic [IDX_W-1:0] idx_r;
  logic v0_r, v1_r;
  logic m0_r, m1_r, status_r;
  logic sel_r, first_r, v6_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PLEN_W-1:0] plen_r;
  logic res_first_r, res_second_r, res_status_r;

  logic [CNT_W-1:0] cnt_sel, cnt_eff, scan_n;
  logic [PLEN_W-1:0] max_p, plen_sat;
  logic full;
  entry_t wr_entry;
  logic match0, match1;

  function automatic logic entry_hit(entry_t e, logic fam, logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] mask;
    for (int k = 0; k < ADDR_W; k++) begin
      mask[ADDR_W-1-k] = (PLEN_W'(k) < e.prefix);
    end
    return (e.fam == fam) && (((e.addr ^ a) & mask) == '0);
  endfunction

  assign cnt_sel  = sel_r ? cnt1_r : cnt0_r;
  assign cnt_eff  = first_r ? '0 : cnt_sel;
  assign full     = (cnt_eff >= LIST_FULL);
  assign max_p    = v6_r ? V6_MAX_PREFIX : V4_MAX_PREFIX;
  assign plen_sat = (plen_r > max_p) ? max_p : plen_r;
  assign wr_entry = '{fam: v6_r, prefix: plen_sat, addr: addr_r};
  assign scan_n   = (cnt0_r > cnt1_r) ? cnt0_r : cnt1_r;

  assign stat.scan_empty = (scan_n == '0);
  assign stat.scan_last  = (idx_r == IDX_W'(scan_n - CNT_W'(1)));

  assign match0 = v0_r && entry_hit(rd0_r, v6_r, addr_r);
  assign match1 = v1_r && entry_hit(rd1_r, v6_r, addr_r);

  // entry stores
  always_ff @(posedge clk) begin
    if (cmd.do_append && !full && !sel_r) begin
      mem0[cnt_eff[IDX_W-1:0]] <= wr_entry;
    end
    if (cmd.do_append && !full && sel_r) begin
      mem1[cnt_eff[IDX_W-1:0]] <= wr_entry;
    end
    rd0_r <= mem0[idx_r];
    rd1_r <= mem1[idx_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt0_r <= '0;
      cnt1_r <= '0;
      idx_r  <= '0;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
    end else begin
      if (cmd.do_append) begin
        if (!sel_r) begin
          cnt0_r <= full ? cnt_eff : cnt_eff + CNT_W'(1);
        end else begin
          cnt1_r <= full ? cnt_eff : cnt_eff + CNT_W'(1);
        end
      end
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      v0_r <= cmd.scan_step && (CNT_W'(idx_r) < cnt0_r);
      v1_r <= cmd.scan_step && (CNT_W'(idx_r) < cnt1_r);
    end
  end

  // transaction capture, accumulation and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_r    <= in_sel;
      first_r  <= in_first;
      v6_r     <= in_v6;
      addr_r   <= in_addr;
      plen_r   <= in_plen;
      m0_r     <= 1'b0;
      m1_r     <= 1'b0;
      status_r <= STATUS_OK;
    end else begin
      if (match0) begin
        m0_r <= 1'b1;
      end
      if (match1) begin
        m1_r <= 1'b1;
      end
      if (cmd.do_append) begin
        status_r <= full ? STATUS_FULL : STATUS_OK;
      end
    end
    if (cmd.load_out) begin
      res_first_r  <= m0_r;
      res_second_r <= m1_r;
      res_status_r <= status_r;
    end
  end

  assign res_first  = res_first_r;
  assign res_second = res_second_r;
  assign res_status = res_status_r;

endmodule
`default_nettype wire

// File: hdl/dual_prefix_list_matcher_top.sv
// top level of the dual prefix list matcher
`default_nettype none
// Holds two lists of up to LIST_ENTRIES IPv4/IPv6 prefixes each and classifies
// addresses against them. An append transaction passes through capture, store
// write and result load. A classify transaction passes through capture, one scan
// step per entry of the longer list, a drain step and result load, or through
// capture and result load alone when both lists are empty: both list memories
// are read at the same index once per cycle and each entry is compared in the
// cycle after its read, so the scan runs over the longer list. One item is
// worked on at a time; the result register lets the next item be accepted
// while the previous result waits to be taken, and a finished item waits in
// its last state for as long as that previous result is still held off.
module dual_prefix_list_matcher_top
  import dplm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // addr_hi [63:0], addr_lo [127:64], prefix_length [135:128]
  input  wire logic [135:0] in_tdata,
  // operation [0], list_select [1], first_entry [2], is_v6 [3]
  input  wire logic [3:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // first_list_match [0], second_list_match [1], zero [7:2]
  output logic [7:0]        out_tdata,
  // status [0]
  output logic [0:0]        out_tuser
);

  cmd_t  cmd;
  stat_t stat;
  logic  res_first, res_second, res_status;

  dplm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  dplm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_sel     (in_tuser[1]),
    .in_first   (in_tuser[2]),
    .in_v6      (in_tuser[3]),
    .in_addr    ({in_tdata[63:0], in_tdata[127:64]}),
    .in_plen    (in_tdata[135:128]),
    .res_first  (res_first),
    .res_second (res_second),
    .res_status (res_status)
  );

  assign out_tdata = {6'b0, res_second, res_first};
  assign out_tuser = res_status;

endmodule
`default_nettype wire
